// ===== rtl/mbrtu_pkg.sv =====
// Package: shared types, constants and CRC helper for the Modbus RTU slave.
package mbrtu_pkg;

  localparam int unsigned RegCount   = 16;
  localparam int unsigned FrameBytes = 256;
  localparam int unsigned RegIdxW    = $clog2(RegCount);
  localparam int unsigned FrmIdxW    = $clog2(FrameBytes);
  localparam int unsigned FrmLenW    = $clog2(FrameBytes + 1);

  localparam logic [1:0]  ReqLink     = 2'd0;
  localparam logic [1:0]  ReqLocWrite = 2'd1;
  localparam logic [1:0]  ReqLocRead  = 2'd2;

  localparam logic [7:0]  FcRead      = 8'h03;
  localparam logic [7:0]  FcWrite     = 8'h06;
  localparam logic [7:0]  FcWriteMul  = 8'h10;
  localparam logic [7:0]  ExcFunc     = 8'h01;
  localparam logic [7:0]  ExcAddr     = 8'h02;
  localparam logic [7:0]  ExcValue    = 8'h03;
  localparam logic [7:0]  ExcFlag     = 8'h80;
  localparam logic [15:0] MaxReadQty  = 16'd125;
  localparam logic [15:0] MaxWriteQty = 16'd123;
  localparam logic [15:0] CrcInit     = 16'hFFFF;
  localparam logic [15:0] CrcPoly     = 16'hA001;

  typedef enum logic [4:0] {
    ST_IDLE,     // wait for an input beat
    ST_LOCRD,    // drive local read result
    ST_HDR0,     // read frame byte 0
    ST_HDR1,     // read frame byte 1
    ST_HDR2,
    ST_HDR3,
    ST_HDR4,
    ST_HDR5,
    ST_HDR6,
    ST_JUDGE,    // decide what to do
    ST_WRFETCH,  // fetch high byte of a write word
    ST_WRLO,     // fetch low byte and write register
    ST_TXBYTE,   // present reply byte, feed CRC
    ST_TXCRCLO,
    ST_TXCRCHI,
    ST_DONE      // clear frame state
  } state_e;

  // reply byte source selection
  typedef enum logic [2:0] {
    SRC_ADDR, SRC_FC, SRC_EXC, SRC_CNT, SRC_REGHI, SRC_REGLO, SRC_ECHO, SRC_EXCFC
  } src_e;

  typedef struct packed {
    logic       link_store;  // store rx byte and update running CRC
    logic       frame_clr;   // reset length and CRC
    logic       loc_write;
    logic       loc_read;    // capture local read value
    logic       fs_rd;       // read frame store at rd_idx
    logic [FrmIdxW-1:0] rd_idx;
    logic [3:0] hdr_sel;     // capture header byte into slot (0..6), 15 none
    logic       ptr_load;    // load reg pointer from start
    logic       ptr_inc;
    logic       wr_hi;       // capture high byte of write word
    logic       wr_reg;      // write register with {hi, fs data}
    logic       txcrc_init;
    logic       tx_feed;     // fold current tx byte into reply CRC
    logic [1:0] tx_mode;     // 0 byte, 1 crc lo, 2 crc hi
  } ctrl_t;

  typedef struct packed {
    logic [FrmLenW-1:0] frame_len;
    logic               crc_ok;
    logic [7:0]         fs_data;
    logic [7:0]         hdr0;
    logic [7:0]         hdr1;
    logic [15:0]        start;
    logic [15:0]        qty;
    logic [7:0]         cnt;
  } stat_t;

  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/mbrtu_datapath.sv =====
// Datapath: frame buffer, running CRC, holding registers, reply formatting.
module mbrtu_datapath import mbrtu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ctrl_t       ctrl_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [15:0] local_address_i,
  input  logic [15:0] local_value_i,
  input  logic [7:0]  slave_address_i,
  input  src_e        src_i,
  input  logic [7:0]  exc_code_i,
  output stat_t       stat_o,
  output logic [7:0]  tx_byte_o,
  output logic [15:0] reg_value_o
);

  logic [7:0]         fs_mem [FrameBytes];
  logic [FrmLenW-1:0] len_q;
  logic [15:0]        crc_q;
  logic [7:0]         fs_data_q;
  logic [15:0]        regs_q [RegCount];
  logic [7:0]         hdr_q [7];
  logic [RegIdxW-1:0] ptr_q;
  logic [7:0]         wr_hi_q;
  logic [15:0]        txcrc_q;
  logic [15:0]        locrd_q;
  logic               loc_in_range;
  logic [15:0]        cur_reg;
  logic [7:0]         cur_byte;

  assign loc_in_range = (local_address_i < 16'(RegCount));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      crc_q <= CrcInit;
    end else if (ctrl_i.frame_clr) begin
      len_q <= '0;
      crc_q <= CrcInit;
    end else if (ctrl_i.link_store && (len_q < FrmLenW'(FrameBytes))) begin
      len_q <= len_q + 1'b1;
      crc_q <= crc_byte(crc_q, rx_byte_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.link_store && (len_q < FrmLenW'(FrameBytes))) begin
      fs_mem[len_q[FrmIdxW-1:0]] <= rx_byte_i;
    end
    if (ctrl_i.fs_rd) begin
      fs_data_q <= fs_mem[ctrl_i.rd_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.hdr_sel < 4'd7) begin
      hdr_q[ctrl_i.hdr_sel[2:0]] <= fs_data_q;
    end
    if (ctrl_i.wr_hi) begin
      wr_hi_q <= fs_data_q;
    end
    if (ctrl_i.loc_read) begin
      locrd_q <= loc_in_range ? regs_q[local_address_i[RegIdxW-1:0]] : 16'h0000;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < RegCount; i++) begin
        regs_q[i] <= 16'h0000;
      end
      regs_q[0] <= 16'h0001;
      regs_q[1] <= 16'h1234;
    end else if (ctrl_i.loc_write && loc_in_range) begin
      regs_q[local_address_i[RegIdxW-1:0]] <= local_value_i;
    end else if (ctrl_i.wr_reg) begin
      regs_q[ptr_q] <= {wr_hi_q, fs_data_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ptr_load) begin
      ptr_q <= hdr_q[3][RegIdxW-1:0];
    end else if (ctrl_i.ptr_inc) begin
      ptr_q <= ptr_q + 1'b1;
    end
    if (ctrl_i.txcrc_init) begin
      txcrc_q <= CrcInit;
    end else if (ctrl_i.tx_feed) begin
      txcrc_q <= crc_byte(txcrc_q, cur_byte);
    end
  end

  assign cur_reg = regs_q[ptr_q];

  always_comb begin
    unique case (src_i)
      SRC_ADDR:  cur_byte = slave_address_i;
      SRC_FC:    cur_byte = hdr_q[1];
      SRC_EXCFC: cur_byte = hdr_q[1] | ExcFlag;
      SRC_EXC:   cur_byte = exc_code_i;
      SRC_CNT:   cur_byte = {hdr_q[5][6:0], 1'b0};
      SRC_REGHI: cur_byte = cur_reg[15:8];
      SRC_REGLO: cur_byte = cur_reg[7:0];
      SRC_ECHO:  cur_byte = fs_data_q;
      default:   cur_byte = 8'h00;
    endcase
  end

  always_comb begin
    case (ctrl_i.tx_mode)
      2'd1:    tx_byte_o = txcrc_q[7:0];
      2'd2:    tx_byte_o = txcrc_q[15:8];
      default: tx_byte_o = cur_byte;
    endcase
  end

  assign reg_value_o      = locrd_q;
  assign stat_o.frame_len = len_q;
  assign stat_o.crc_ok    = (crc_q == 16'h0000);
  assign stat_o.fs_data   = fs_data_q;
  assign stat_o.hdr0      = hdr_q[0];
  assign stat_o.hdr1      = hdr_q[1];
  assign stat_o.start     = {hdr_q[2], hdr_q[3]};
  assign stat_o.qty       = {hdr_q[4], hdr_q[5]};
  assign stat_o.cnt       = hdr_q[6];

endmodule

// ===== rtl/mbrtu_ctrl.sv =====
// Controller: sequences frame judging, register writes and reply beats.
module mbrtu_ctrl import mbrtu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic        frame_end_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        result_kind_o,
  output logic        last_o,
  input  logic [7:0]  slave_address_i,
  input  stat_t       stat_i,
  output ctrl_t       ctrl_o,
  output src_e        src_o,
  output logic [7:0]  exc_code_o
);

  state_e state_q, state_d;
  // reply plan
  logic       bcast_q, bcast_d;
  logic       is_exc_q, is_exc_d;
  logic [7:0] exc_q, exc_d;
  logic [7:0] fc_q, fc_d;
  logic [7:0] pos_q, pos_d;      // reply byte position
  logic [7:0] nbytes_q, nbytes_d; // body length without CRC
  logic [7:0] wcnt_q, wcnt_d;    // words left to write
  logic [FrmIdxW-1:0] ridx_q, ridx_d;
  logic [3:0] hidx_q, hidx_d;
  logic       fire_in, fire_out;
  logic [16:0] range_end;
  logic       addr_ok;

  assign fire_in  = in_valid_i && in_ready_o;
  assign fire_out = out_valid_o && out_ready_i;
  assign exc_code_o = exc_q;
  assign range_end = {1'b0, stat_i.start} + {1'b0, stat_i.qty};
  assign addr_ok = (stat_i.hdr0 == slave_address_i) || (stat_i.hdr0 == 8'h00);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      bcast_q  <= 1'b0;
      is_exc_q <= 1'b0;
      exc_q    <= '0;
      fc_q     <= '0;
      pos_q    <= '0;
      nbytes_q <= '0;
      wcnt_q   <= '0;
      ridx_q   <= '0;
      hidx_q   <= '0;
    end else begin
      state_q  <= state_d;
      bcast_q  <= bcast_d;
      is_exc_q <= is_exc_d;
      exc_q    <= exc_d;
      fc_q     <= fc_d;
      pos_q    <= pos_d;
      nbytes_q <= nbytes_d;
      wcnt_q   <= wcnt_d;
      ridx_q   <= ridx_d;
      hidx_q   <= hidx_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    bcast_d  = bcast_q;
    is_exc_d = is_exc_q;
    exc_d    = exc_q;
    fc_d     = fc_q;
    pos_d    = pos_q;
    nbytes_d = nbytes_q;
    wcnt_d   = wcnt_q;
    ridx_d   = ridx_q;
    hidx_d   = hidx_q;
    ctrl_o   = '0;
    ctrl_o.hdr_sel = 4'hF;
    ctrl_o.rd_idx  = ridx_q;
    src_o    = SRC_ADDR;
    in_ready_o    = 1'b0;
    out_valid_o   = 1'b0;
    result_kind_o = 1'b0;
    last_o        = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (req_type_i)
            ReqLink: begin
              ctrl_o.link_store = 1'b1;
              if (frame_end_i) begin
                state_d = ST_HDR0;
              end
            end
            ReqLocWrite: ctrl_o.loc_write = 1'b1;
            ReqLocRead: begin
              ctrl_o.loc_read = 1'b1;
              state_d = ST_LOCRD;
            end
            default: ;
          endcase
        end
      end
      ST_LOCRD: begin
        out_valid_o   = 1'b1;
        result_kind_o = 1'b1;
        last_o        = 1'b1;
        if (out_ready_i) state_d = ST_IDLE;
      end
      ST_HDR0: begin
        // short, bad CRC: drop at once; else start header reads
        if (stat_i.frame_len < FrmLenW'(4) || !stat_i.crc_ok) begin
          state_d = ST_DONE;
        end else begin
          ctrl_o.fs_rd  = 1'b1;
          ctrl_o.rd_idx = '0;
          hidx_d = 4'd0;
          state_d = ST_HDR1;
        end
      end
      ST_HDR1, ST_HDR2, ST_HDR3, ST_HDR4, ST_HDR5, ST_HDR6: begin
        // pipeline: read byte hidx+1, capture byte hidx
        ctrl_o.hdr_sel = hidx_q;
        ctrl_o.fs_rd  = 1'b1;
        ctrl_o.rd_idx = FrmIdxW'(hidx_q + 4'd1);
        hidx_d  = hidx_q + 4'd1;
        state_d = state_e'(state_q + 1'b1);
      end
      ST_JUDGE: begin
        ctrl_o.hdr_sel = 4'd6;
        // hdr6 not yet valid in stat this cycle; use fs_data for cnt
        bcast_d  = (stat_i.hdr0 == 8'h00);
        fc_d     = stat_i.hdr1;
        is_exc_d = 1'b0;
        pos_d    = '0;
        ctrl_o.txcrc_init = 1'b1;
        ctrl_o.ptr_load   = 1'b1;
        state_d  = ST_TXBYTE;
        if (!addr_ok) begin
          state_d = ST_DONE;
        end else if (stat_i.hdr1 == FcRead) begin
          if (stat_i.frame_len != FrmLenW'(8)) begin
            is_exc_d = 1'b1; exc_d = ExcValue;
          end else if (stat_i.qty == 16'd0 || stat_i.qty > MaxReadQty ||
                       range_end > 17'(RegCount)) begin
            is_exc_d = 1'b1; exc_d = ExcAddr;
          end else begin
            nbytes_d = 8'(8'd3 + {stat_i.qty[6:0], 1'b0});
          end
        end else if (stat_i.hdr1 == FcWrite) begin
          if (stat_i.frame_len != FrmLenW'(8)) begin
            is_exc_d = 1'b1; exc_d = ExcValue;
          end else if (stat_i.start >= 16'(RegCount)) begin
            is_exc_d = 1'b1; exc_d = ExcAddr;
          end else begin
            nbytes_d = 8'd6;
            wcnt_d   = 8'd1;
            ridx_d   = FrmIdxW'(4);
            state_d  = ST_WRFETCH;
          end
        end else if (stat_i.hdr1 == FcWriteMul) begin
          if (stat_i.frame_len < FrmLenW'(9)) begin
            is_exc_d = 1'b1; exc_d = ExcValue;
          end else if (stat_i.frame_len != FrmLenW'(9) + FrmLenW'(stat_i.fs_data) ||
                       stat_i.fs_data != {stat_i.qty[6:0], 1'b0} ||
                       stat_i.qty == 16'd0 || stat_i.qty > MaxWriteQty ||
                       range_end > 17'(RegCount)) begin
            is_exc_d = 1'b1; exc_d = ExcAddr;
          end else begin
            nbytes_d = 8'd6;
            wcnt_d   = stat_i.qty[7:0];
            ridx_d   = FrmIdxW'(7);
            state_d  = ST_WRFETCH;
          end
        end else begin
          is_exc_d = 1'b1; exc_d = ExcFunc;
        end
        if (addr_ok && is_exc_d) begin
          nbytes_d = 8'd3;
          state_d  = ST_TXBYTE;
        end
        if (state_d == ST_TXBYTE && bcast_d) begin
          state_d = ST_DONE;
        end
      end
      ST_WRFETCH: begin
        ctrl_o.fs_rd  = 1'b1;
        ctrl_o.rd_idx = ridx_q;
        ridx_d  = ridx_q + 1'b1;
        state_d = ST_WRLO;
      end
      ST_WRLO: begin
        ctrl_o.wr_hi  = 1'b1;
        ctrl_o.fs_rd  = 1'b1;
        ctrl_o.rd_idx = ridx_q;
        ridx_d  = ridx_q + 1'b1;
        state_d = ST_WRFETCH;
        if (pos_q == 8'd1) begin
          // second half: data is in fs_data now; write
          ctrl_o.wr_hi  = 1'b0;
          ctrl_o.fs_rd  = 1'b0;
          ctrl_o.wr_reg = 1'b1;
          ctrl_o.ptr_inc = 1'b1;
          ridx_d = ridx_q;
          pos_d  = '0;
          wcnt_d = wcnt_q - 1'b1;
          if (wcnt_q == 8'd1) begin
            ctrl_o.ptr_load = 1'b1;
            state_d = bcast_q ? ST_DONE : ST_TXBYTE;
          end
        end else begin
          pos_d   = 8'd1;
          state_d = ST_WRLO;
        end
      end
      ST_TXBYTE: begin
        // choose source for reply byte at pos
        if (pos_q == 8'd0) begin
          src_o = SRC_ADDR;
        end else if (pos_q == 8'd1) begin
          src_o = is_exc_q ? SRC_EXCFC : SRC_FC;
        end else if (is_exc_q) begin
          src_o = SRC_EXC;
        end else if (fc_q == FcRead) begin
          if (pos_q == 8'd2) src_o = SRC_CNT;
          else src_o = pos_q[0] ? SRC_REGHI : SRC_REGLO;
        end else begin
          src_o = SRC_ECHO;
        end
        if (is_exc_q) begin
          ctrl_o.tx_mode = 2'd0;
        end
        out_valid_o = 1'b1;
        if (fc_q != FcRead && !is_exc_q && pos_q >= 8'd1 && pos_q < 8'd5) begin
          // prefetch echo byte pos+1 while showing this one
          ctrl_o.fs_rd  = fire_out;
          ctrl_o.rd_idx = FrmIdxW'(pos_q + 8'd1);
        end
        if (fire_out) begin
          ctrl_o.tx_feed = 1'b1;
          pos_d = pos_q + 1'b1;
          if (fc_q == FcRead && !is_exc_q && pos_q > 8'd2 && !pos_q[0]) begin
            ctrl_o.ptr_inc = 1'b1;
          end
          if (pos_q + 8'd1 == nbytes_q) state_d = ST_TXCRCLO;
        end
      end
      ST_TXCRCLO: begin
        ctrl_o.tx_mode = 2'd1;
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = ST_TXCRCHI;
      end
      ST_TXCRCHI: begin
        ctrl_o.tx_mode = 2'd2;
        out_valid_o = 1'b1;
        last_o      = 1'b1;
        if (out_ready_i) state_d = ST_DONE;
      end
      ST_DONE: begin
        ctrl_o.frame_clr = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  property p_no_accept_busy;
    @(posedge clk_i) disable iff (!rst_ni) fire_in |-> (state_q == ST_IDLE);
  endproperty
  a_no_accept_busy: assert property (p_no_accept_busy) else $error("accept while busy");

  a_last_crc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_o && !result_kind_o) |-> (state_q == ST_TXCRCHI))
    else $error("last outside CRC high byte");

  a_clear_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TXCRCHI && out_ready_i) |=> (state_q == ST_DONE))
    else $error("frame not cleared after reply");

endmodule

// ===== rtl/modbus_rtu_holding_register_slave.sv =====
// Top level: Modbus RTU holding-register slave.
//  channel | dir | handshake                 | payload
//  in      | in  | in_valid_i / in_ready_o   | req_type, rx_byte, frame_end, local_*
//  out     | out | out_valid_o / out_ready_i | result_kind, tx_byte, last, reg_value
//  cfg     | in  | cfg_valid_i / cfg_ready_o | cfg_data_i (slave address)
// A link byte is stored and a local write applied; a local read adds one result beat.
// End of frame: header reads and judging (dropped at once when short or bad CRC),
// a fetch and a write per written register, the reply beats plus 2 CRC beats, then a clear.
// Reset clears all control state, the frame length and CRC, and loads the
// holding registers with their defaults.
// Output stalls hold the controller in place; input is taken only when idle.
module modbus_rtu_holding_register_slave import mbrtu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        frame_end_i,
  input  logic [15:0] local_address_i,
  input  logic [15:0] local_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        result_kind_o,
  output logic [7:0]  tx_byte_o,
  output logic        last_o,
  output logic [15:0] reg_value_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i
);

  logic [7:0] slave_addr_q;
  ctrl_t      ctrl;
  stat_t      stat;
  src_e       src;
  logic [7:0] exc_code;
  logic [7:0] tx_raw;
  logic [15:0] reg_raw;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_addr_q <= 8'h01;
    end else if (cfg_valid_i) begin
      slave_addr_q <= cfg_data_i;
    end
  end

  mbrtu_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .req_type_i, .frame_end_i,
    .out_valid_o, .out_ready_i, .result_kind_o, .last_o,
    .slave_address_i(slave_addr_q), .stat_i(stat), .ctrl_o(ctrl),
    .src_o(src), .exc_code_o(exc_code)
  );

  mbrtu_datapath u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .rx_byte_i, .local_address_i, .local_value_i,
    .slave_address_i(slave_addr_q), .src_i(src), .exc_code_i(exc_code),
    .stat_o(stat), .tx_byte_o(tx_raw), .reg_value_o(reg_raw)
  );

  assign tx_byte_o   = result_kind_o ? 8'h00 : tx_raw;
  assign reg_value_o = result_kind_o ? reg_raw : 16'h0000;

endmodule
